// ===== rtl/kmer_complete_linkage_cluster_defines.svh =====
// assertion macros for the k-mer complete-linkage clustering block
// used by the port checker, needs i_clk and i_rst_n in the calling scope
`ifndef KMER_COMPLETE_LINKAGE_CLUSTER_DEFINES_SVH
`define KMER_COMPLETE_LINKAGE_CLUSTER_DEFINES_SVH

// same-cycle implication
`define KCL_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kcl check failed");

// next-cycle implication
`define KCL_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kcl check failed");

`endif

// ===== rtl/kcl_pkg.sv =====
// shared types and constants for the k-mer complete-linkage clustering block
// no dependencies
`timescale 1ns / 1ps

package kcl_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int KMER_LEN_DEF  = 10;
    localparam int DIST_BITS_DEF = 16;

    localparam int SYMS      = 5;
    localparam int ACT_W     = 2;
    localparam int SYM_W     = 3;
    localparam int TVAL_W    = 16;
    localparam int CODE_W    = 24;
    localparam int IDX_W     = 6;
    localparam int MDIST_W   = 20;

    localparam logic [MDIST_W-1:0] DIST_SAT = {MDIST_W{1'b1}};

    // ceil(2^26 / 5), exact quotient for any 24-bit dividend
    localparam logic [CODE_W-1:0] RECIP5      = 24'd13421773;
    localparam int                RECIP_SHIFT = 26;

    typedef enum logic [ACT_W-1:0] {
        ACT_TABLE = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_SPARE = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CV_RD,
        S_CV_LD,
        S_CV_DIG,
        S_CV_WR,
        S_DI_RD,
        S_DI_LD,
        S_DJ_RD,
        S_DJ_LD,
        S_DSUM,
        S_DW1,
        S_DW2,
        S_SRCH,
        S_SRCH_END,
        S_EMIT,
        S_UA,
        S_UB,
        S_UM,
        S_UW
    } t_state;

endpackage

// ===== rtl/kcl_in_if.sv =====
// request channel of the k-mer clustering block: valid/ready plus command payload
// depends on kcl_pkg
`timescale 1ns / 1ps

interface kcl_in_if;
    logic                            valid;
    logic                            ready;
    logic [kcl_pkg::ACT_W-1:0]       action;
    logic [kcl_pkg::SYM_W-1:0]       table_row;
    logic [kcl_pkg::SYM_W-1:0]       table_col;
    logic [kcl_pkg::TVAL_W-1:0]      table_value;
    logic [kcl_pkg::CODE_W-1:0]      kmer_code;

    modport source (output valid, action, table_row, table_col, table_value, kmer_code,
                    input ready);
    modport sink   (input valid, action, table_row, table_col, table_value, kmer_code,
                    output ready);
endinterface

// ===== rtl/kcl_out_if.sv =====
// result channel of the k-mer clustering block: valid/ready plus merge payload
// depends on kcl_pkg
`timescale 1ns / 1ps

interface kcl_out_if;
    logic                            valid;
    logic                            ready;
    logic [kcl_pkg::IDX_W-1:0]       survivor_index;
    logic [kcl_pkg::IDX_W-1:0]       absorbed_index;
    logic [kcl_pkg::MDIST_W-1:0]     merge_distance;
    logic                            last_merge;

    modport source (output valid, survivor_index, absorbed_index, merge_distance, last_merge,
                    input ready);
    modport sink   (input valid, survivor_index, absorbed_index, merge_distance, last_merge,
                    output ready);
endinterface

// ===== rtl/kmer_complete_linkage_cluster.sv =====
// top level of the k-mer complete-linkage clustering block
// depends on kcl_pkg, kcl_in_if, kcl_out_if
//
// channel  dir  payload                                                  handshake
// i_req    in   action, table_row, table_col, table_value, kmer_code    valid/ready
// o_res    out  survivor_index, absorbed_index, merge_distance, last    valid/ready
//
// table writes and loads are handled in the idle state; i_req.ready is high only while idle
// a run splits each code into base-5 digits, fills the distance matrix pair by pair
// (both halves written), then per merge scans all pairs, picks and emits the closest,
// and updates live columns with the max of the two merged rows, skipping other columns
// the distance memory has one read and one write port, which sets the scan length
// a pending result stalls the next merge only when it is still untaken at emit time
// synchronous active-low reset clears control, live flags and the item count
`timescale 1ns / 1ps

module kmer_complete_linkage_cluster #(
    parameter int MAX_ITEMS = kcl_pkg::MAX_ITEMS_DEF,
    parameter int KMER_LEN  = kcl_pkg::KMER_LEN_DEF,
    parameter int DIST_BITS = kcl_pkg::DIST_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kcl_in_if.sink    i_req,
    kcl_out_if.source o_res
);

    localparam int IW   = $clog2(MAX_ITEMS);
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int DW   = 3 * KMER_LEN;
    localparam int CW   = (DW > kcl_pkg::CODE_W) ? DW : kcl_pkg::CODE_W;
    localparam int TW   = (DIST_BITS < kcl_pkg::TVAL_W) ? DIST_BITS : kcl_pkg::TVAL_W;
    localparam int PW   = $clog2(KMER_LEN + 1);
    localparam int AW   = 2 * IW;
    localparam int MW   = kcl_pkg::MDIST_W;

    kcl_pkg::t_state r_state, n_state;

    logic [TW-1:0]   r_tbl [0:kcl_pkg::SYMS-1][0:kcl_pkg::SYMS-1];
    logic [CW-1:0]   r_imem [0:MAX_ITEMS-1];
    logic [MW-1:0]   r_dmem [0:(1 << AW)-1];
    logic [CW-1:0]   r_irdata;
    logic [MW-1:0]   r_drdata;
    logic [MAX_ITEMS-1:0] r_live;

    logic [CNTW-1:0] r_cnt, r_step;
    logic [IW-1:0]   r_i, r_j, r_k1, r_k2, r_si, r_sj;
    logic [PW-1:0]   r_p;
    logic [kcl_pkg::CODE_W-1:0] r_a;
    logic [DW-1:0]   r_dig, r_ci, r_wi, r_cj;
    logic [MW-1:0]   r_sum, r_best, r_ua, r_um;
    logic            r_found, r_sv;

    logic            r_ov;
    logic [IW-1:0]   r_o_surv, r_o_abs;
    logic [MW-1:0]   r_o_dist;
    logic            r_o_last;

    logic            imem_we;
    logic [IW-1:0]   imem_waddr, imem_raddr;
    logic [CW-1:0]   imem_wdata;
    logic            dmem_we;
    logic [AW-1:0]   dmem_waddr, dmem_raddr;
    logic [MW-1:0]   dmem_wdata;

    logic            in_acc, out_free, last_step;
    logic            j_end, i_end, uj_end, upd_col;
    logic [2*kcl_pkg::CODE_W-1:0] prod;
    logic [kcl_pkg::CODE_W-1:0]   quo;
    logic [2:0]      digit;
    logic [MW:0]     sum_ext;
    logic [MW-1:0]   sum_sat, umax;
    logic            take;

    assign in_acc    = i_req.valid && i_req.ready;
    assign out_free  = !r_ov || o_res.ready;
    assign last_step = (r_step == r_cnt - CNTW'(1));
    assign j_end     = (CNTW'(r_j) + CNTW'(1) == CNTW'(r_i));
    assign i_end     = (CNTW'(r_i) + CNTW'(1) == r_cnt);
    assign uj_end    = (CNTW'(r_j) + CNTW'(1) == r_cnt);
    assign upd_col   = r_live[r_j] && (r_j != r_k1);

    assign prod    = r_a * kcl_pkg::RECIP5;
    assign quo     = kcl_pkg::CODE_W'(prod >> kcl_pkg::RECIP_SHIFT);
    assign digit   = 3'(r_a - ((quo << 2) + quo));
    assign sum_ext = {1'b0, r_sum} + (MW + 1)'(r_tbl[r_wi[2:0]][r_cj[2:0]]);
    assign sum_sat = sum_ext[MW] ? kcl_pkg::DIST_SAT : sum_ext[MW-1:0];
    assign umax    = (r_ua > r_drdata) ? r_ua : r_drdata;
    assign take    = r_sv && (!r_found || r_drdata < r_best);

    assign i_req.ready          = (r_state == kcl_pkg::S_IDLE);
    assign o_res.valid          = r_ov;
    assign o_res.survivor_index = kcl_pkg::IDX_W'(r_o_surv);
    assign o_res.absorbed_index = kcl_pkg::IDX_W'(r_o_abs);
    assign o_res.merge_distance = r_o_dist;
    assign o_res.last_merge     = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kcl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        imem_we    = 1'b0;
        imem_waddr = r_i;
        imem_wdata = CW'(r_dig);
        imem_raddr = r_i;
        dmem_we    = 1'b0;
        dmem_waddr = {r_i, r_j};
        dmem_wdata = r_sum;
        dmem_raddr = {r_i, r_j};
        case (r_state)
            kcl_pkg::S_IDLE: begin
                imem_waddr = IW'(r_cnt);
                imem_wdata = CW'(i_req.kmer_code);
                if (in_acc) begin
                    case (kcl_pkg::t_action'(i_req.action))
                        kcl_pkg::ACT_LOAD: begin
                            imem_we = (r_cnt < CNTW'(MAX_ITEMS));
                        end
                        kcl_pkg::ACT_RUN: begin
                            if (r_cnt >= CNTW'(2)) n_state = kcl_pkg::S_CV_RD;
                        end
                        default: ;
                    endcase
                end
            end
            kcl_pkg::S_CV_RD:  n_state = kcl_pkg::S_CV_LD;
            kcl_pkg::S_CV_LD:  n_state = kcl_pkg::S_CV_DIG;
            kcl_pkg::S_CV_DIG: begin
                if (r_p == PW'(KMER_LEN - 1)) n_state = kcl_pkg::S_CV_WR;
            end
            kcl_pkg::S_CV_WR: begin
                imem_we = 1'b1;
                n_state = i_end ? kcl_pkg::S_DI_RD : kcl_pkg::S_CV_RD;
            end
            kcl_pkg::S_DI_RD: n_state = kcl_pkg::S_DI_LD;
            kcl_pkg::S_DI_LD: n_state = kcl_pkg::S_DJ_RD;
            kcl_pkg::S_DJ_RD: begin
                imem_raddr = r_j;
                n_state    = kcl_pkg::S_DJ_LD;
            end
            kcl_pkg::S_DJ_LD: n_state = kcl_pkg::S_DSUM;
            kcl_pkg::S_DSUM: begin
                if (r_p == PW'(KMER_LEN - 1)) n_state = kcl_pkg::S_DW1;
            end
            kcl_pkg::S_DW1: begin
                dmem_we = 1'b1;
                n_state = kcl_pkg::S_DW2;
            end
            kcl_pkg::S_DW2: begin
                dmem_we    = 1'b1;
                dmem_waddr = {r_j, r_i};
                if (!j_end)     n_state = kcl_pkg::S_DJ_RD;
                else if (i_end) n_state = kcl_pkg::S_SRCH;
                else            n_state = kcl_pkg::S_DI_RD;
            end
            kcl_pkg::S_SRCH: begin
                if (j_end && i_end) n_state = kcl_pkg::S_SRCH_END;
            end
            kcl_pkg::S_SRCH_END: n_state = kcl_pkg::S_EMIT;
            kcl_pkg::S_EMIT: begin
                if (out_free) n_state = last_step ? kcl_pkg::S_IDLE : kcl_pkg::S_UA;
            end
            kcl_pkg::S_UA: begin
                dmem_raddr = {r_k1, r_j};
                if (upd_col)     n_state = kcl_pkg::S_UB;
                else if (uj_end) n_state = kcl_pkg::S_SRCH;
            end
            kcl_pkg::S_UB: begin
                dmem_raddr = {r_k2, r_j};
                n_state    = kcl_pkg::S_UM;
            end
            kcl_pkg::S_UM: begin
                dmem_we    = 1'b1;
                dmem_waddr = {r_k1, r_j};
                dmem_wdata = umax;
                n_state    = kcl_pkg::S_UW;
            end
            kcl_pkg::S_UW: begin
                dmem_we    = 1'b1;
                dmem_waddr = {r_j, r_k1};
                dmem_wdata = r_um;
                n_state    = uj_end ? kcl_pkg::S_SRCH : kcl_pkg::S_UA;
            end
            default: n_state = kcl_pkg::S_IDLE;
        endcase
    end

    // item and distance memories
    always_ff @(posedge i_clk) begin
        if (imem_we) r_imem[imem_waddr] <= imem_wdata;
        r_irdata <= r_imem[imem_raddr];
        if (dmem_we) r_dmem[dmem_waddr] <= dmem_wdata;
        r_drdata <= r_dmem[dmem_raddr];
    end

    // symbol table
    always_ff @(posedge i_clk) begin
        if (in_acc && kcl_pkg::t_action'(i_req.action) == kcl_pkg::ACT_TABLE
                && i_req.table_row < kcl_pkg::SYM_W'(kcl_pkg::SYMS)
                && i_req.table_col < kcl_pkg::SYM_W'(kcl_pkg::SYMS)) begin
            r_tbl[i_req.table_row][i_req.table_col] <= TW'(i_req.table_value);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_live <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_state == kcl_pkg::S_EMIT && out_free) r_ov <= 1'b1;
            else if (r_ov && o_res.ready)              r_ov <= 1'b0;
            case (r_state)
                kcl_pkg::S_IDLE: begin
                    if (in_acc) begin
                        case (kcl_pkg::t_action'(i_req.action))
                            kcl_pkg::ACT_LOAD: begin
                                if (r_cnt < CNTW'(MAX_ITEMS)) r_cnt <= r_cnt + CNTW'(1);
                            end
                            kcl_pkg::ACT_RUN: begin
                                for (int k = 0; k < MAX_ITEMS; k++) begin
                                    r_live[k] <= (CNTW'(k) < r_cnt) && (r_cnt >= CNTW'(2));
                                end
                                if (r_cnt < CNTW'(2)) r_cnt <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                kcl_pkg::S_EMIT: begin
                    if (out_free) begin
                        if (last_step) begin
                            r_cnt  <= '0;
                            r_live <= '0;
                        end else begin
                            r_live[r_k2] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            kcl_pkg::S_IDLE: begin
                r_i <= '0;
            end
            kcl_pkg::S_CV_LD: begin
                r_a <= r_irdata[kcl_pkg::CODE_W-1:0];
                r_p <= '0;
            end
            kcl_pkg::S_CV_DIG: begin
                r_a   <= quo;
                r_dig <= (r_dig >> 3) | (DW'(digit) << (DW - 3));
                r_p   <= r_p + PW'(1);
            end
            kcl_pkg::S_CV_WR: begin
                r_i <= i_end ? IW'(1) : r_i + IW'(1);
            end
            kcl_pkg::S_DI_LD: begin
                r_ci <= r_irdata[DW-1:0];
                r_j  <= '0;
            end
            kcl_pkg::S_DJ_LD: begin
                r_cj  <= r_irdata[DW-1:0];
                r_wi  <= r_ci;
                r_sum <= '0;
                r_p   <= '0;
            end
            kcl_pkg::S_DSUM: begin
                r_sum <= sum_sat;
                r_wi  <= r_wi >> 3;
                r_cj  <= r_cj >> 3;
                r_p   <= r_p + PW'(1);
            end
            kcl_pkg::S_DW2: begin
                if (!j_end) begin
                    r_j <= r_j + IW'(1);
                end else if (i_end) begin
                    r_i     <= IW'(1);
                    r_j     <= '0;
                    r_step  <= CNTW'(1);
                    r_found <= 1'b0;
                    r_sv    <= 1'b0;
                end else begin
                    r_i <= r_i + IW'(1);
                end
            end
            kcl_pkg::S_SRCH: begin
                r_sv <= r_live[r_i] && r_live[r_j];
                r_si <= r_i;
                r_sj <= r_j;
                if (take) begin
                    r_best  <= r_drdata;
                    r_k1    <= r_si;
                    r_k2    <= r_sj;
                    r_found <= 1'b1;
                end
                if (j_end) begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            kcl_pkg::S_SRCH_END: begin
                r_sv <= 1'b0;
                if (take) begin
                    r_best  <= r_drdata;
                    r_k1    <= r_si;
                    r_k2    <= r_sj;
                    r_found <= 1'b1;
                end
            end
            kcl_pkg::S_EMIT: begin
                if (out_free) begin
                    r_o_surv <= r_k1;
                    r_o_abs  <= r_k2;
                    r_o_dist <= r_best;
                    r_o_last <= last_step;
                    r_j      <= '0;
                end
            end
            kcl_pkg::S_UA: begin
                if (!upd_col) begin
                    if (uj_end) begin
                        r_i     <= IW'(1);
                        r_j     <= '0;
                        r_step  <= r_step + CNTW'(1);
                        r_found <= 1'b0;
                        r_sv    <= 1'b0;
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
            end
            kcl_pkg::S_UB: begin
                r_ua <= r_drdata;
            end
            kcl_pkg::S_UM: begin
                r_um <= umax;
            end
            kcl_pkg::S_UW: begin
                if (uj_end) begin
                    r_i     <= IW'(1);
                    r_j     <= '0;
                    r_step  <= r_step + CNTW'(1);
                    r_found <= 1'b0;
                    r_sv    <= 1'b0;
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/kcl_checker.sv =====
// port-level checks for the k-mer clustering block, bound to the top level
// depends on kmer_complete_linkage_cluster_defines.svh and kcl_pkg
`timescale 1ns / 1ps
`include "kmer_complete_linkage_cluster_defines.svh"

module kcl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [kcl_pkg::IDX_W-1:0]     i_surv,
    input logic [kcl_pkg::IDX_W-1:0]     i_abs,
    input logic [kcl_pkg::MDIST_W-1:0]   i_dist,
    input logic                          i_last
);

    // survivor always has the larger index
    `KCL_HOLDS(a_surv_above_abs, i_valid, i_surv > i_abs)

    // nothing follows the final merge of a run directly
    `KCL_NEXT(a_quiet_after_last, i_valid && i_ready && i_last, !i_valid)

    // stalled result holds
    `KCL_NEXT(a_res_hold, i_valid && !i_ready,
              i_valid && $stable(i_surv) && $stable(i_abs) && $stable(i_dist) && $stable(i_last))

endmodule

bind kmer_complete_linkage_cluster kcl_checker u_kcl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_surv  (o_res.survivor_index),
    .i_abs   (o_res.absorbed_index),
    .i_dist  (o_res.merge_distance),
    .i_last  (o_res.last_merge)
);

// ===== sim/kmer_complete_linkage_cluster_tb.sv =====
// testbench for the k-mer complete-linkage clustering block: directed and random
// table writes, k-mer loads and runs, checked against a built-in clustering predictor
// depends on kcl_pkg, kcl_in_if, kcl_out_if and kmer_complete_linkage_cluster
`timescale 1ns / 1ps

module kmer_complete_linkage_cluster_tb;

    localparam int NITEMS   = 64;
    localparam int NDIGITS  = 10;
    localparam int WD_LIMIT = 400000;

    typedef struct packed {
        logic [kcl_pkg::ACT_W-1:0]  action;
        logic [kcl_pkg::SYM_W-1:0]  row;
        logic [kcl_pkg::SYM_W-1:0]  col;
        logic [kcl_pkg::TVAL_W-1:0] value;
        logic [kcl_pkg::CODE_W-1:0] code;
    } t_req;

    typedef struct packed {
        logic [kcl_pkg::IDX_W-1:0]   survivor;
        logic [kcl_pkg::IDX_W-1:0]   absorbed;
        logic [kcl_pkg::MDIST_W-1:0] mdist;
        logic                        last;
    } t_merge;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kcl_in_if  req_if ();
    kcl_out_if res_if ();

    kmer_complete_linkage_cluster uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [kcl_pkg::TVAL_W-1:0]  sym_dist [kcl_pkg::SYMS*kcl_pkg::SYMS];
    logic [kcl_pkg::CODE_W-1:0]  codes    [NITEMS];
    logic [kcl_pkg::MDIST_W-1:0] dmat     [NITEMS][NITEMS];
    logic                        alive    [NITEMS];
    int                          n_loaded = 0;

    t_req   pending_reqs [$];
    t_merge merges_due   [$];
    int     n_errors = 0;
    int     n_accepted = 0;
    int     n_merges_seen = 0;
    int     n_runs = 0;
    bit     long_stall;
    bit     hold_send;
    int     idle_cycles = 0;

    task automatic queue_req(t_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endtask

    function automatic logic [kcl_pkg::MDIST_W-1:0] kmer_dist(
            logic [kcl_pkg::CODE_W-1:0] a, logic [kcl_pkg::CODE_W-1:0] b);
        int unsigned x, y, s;
        x = 32'(a);
        y = 32'(b);
        s = 0;
        for (int d = 0; d < NDIGITS; d++) begin
            s += 32'(sym_dist[(x % kcl_pkg::SYMS) * kcl_pkg::SYMS + (y % kcl_pkg::SYMS)]);
            if (s > 32'hFFFFF) s = 32'hFFFFF;
            x /= kcl_pkg::SYMS;
            y /= kcl_pkg::SYMS;
        end
        return s[kcl_pkg::MDIST_W-1:0];
    endfunction

    task automatic cluster_loaded();
        int r, k1, k2;
        logic [kcl_pkg::MDIST_W-1:0] best, m;
        bit found;
        t_merge res;
        r = n_loaded;
        n_runs++;
        for (int i = 0; i < r; i++) begin
            alive[i] = 1'b1;
            dmat[i][i] = '0;
            for (int j = 0; j < i; j++) begin
                dmat[i][j] = kmer_dist(codes[i], codes[j]);
                dmat[j][i] = dmat[i][j];
            end
        end
        for (int t = 1; t + 1 <= r; t++) begin
            found = 0;
            best = '0;
            k1 = 0;
            k2 = 0;
            for (int i = 0; i < r; i++) begin
                if (!alive[i]) continue;
                for (int j = 0; j < i; j++) begin
                    if (alive[j] && (!found || dmat[i][j] < best)) begin
                        best = dmat[i][j];
                        k1 = i;
                        k2 = j;
                        found = 1;
                    end
                end
            end
            if (!found) break;
            alive[k2] = 1'b0;
            for (int j = 0; j < r; j++) begin
                if (alive[j] && j != k1) begin
                    m = dmat[k1][j] > dmat[k2][j] ? dmat[k1][j] : dmat[k2][j];
                    dmat[k1][j] = m;
                    dmat[j][k1] = m;
                end
            end
            res.survivor = k1[kcl_pkg::IDX_W-1:0];
            res.absorbed = k2[kcl_pkg::IDX_W-1:0];
            res.mdist = best;
            res.last = (t + 1 == r);
            merges_due.insert(merges_due.size(), res);
        end
        n_loaded = 0;
        for (int i = 0; i < NITEMS; i++) alive[i] = 1'b0;
    endtask

    task automatic predict_request(t_req q);
        case (q.action)
            kcl_pkg::ACT_TABLE: begin
                if (q.row < kcl_pkg::SYMS && q.col < kcl_pkg::SYMS)
                    sym_dist[q.row * kcl_pkg::SYMS + q.col] = q.value;
            end
            kcl_pkg::ACT_LOAD: begin
                if (n_loaded < NITEMS) begin
                    codes[n_loaded] = q.code;
                    alive[n_loaded] = 1'b1;
                    n_loaded++;
                end
            end
            kcl_pkg::ACT_RUN: cluster_loaded();
            default: ;
        endcase
    endtask

    // stimulus helpers
    function automatic t_req mk_table(int r, int c, int v);
        t_req q;
        q = '0;
        q.action = kcl_pkg::ACT_TABLE;
        q.row = kcl_pkg::SYM_W'(r);
        q.col = kcl_pkg::SYM_W'(c);
        q.value = kcl_pkg::TVAL_W'(v);
        q.code = kcl_pkg::CODE_W'($urandom);
        return q;
    endfunction

    function automatic t_req mk_load(logic [kcl_pkg::CODE_W-1:0] code);
        t_req q;
        q = '0;
        q.action = kcl_pkg::ACT_LOAD;
        q.row = kcl_pkg::SYM_W'($urandom);
        q.col = kcl_pkg::SYM_W'($urandom);
        q.value = kcl_pkg::TVAL_W'($urandom);
        q.code = code;
        return q;
    endfunction

    function automatic t_req mk_run();
        t_req q;
        q = mk_load(kcl_pkg::CODE_W'($urandom));
        q.action = kcl_pkg::ACT_RUN;
        return q;
    endfunction

    function automatic logic [kcl_pkg::CODE_W-1:0] rand_code();
        case ($urandom_range(0, 3))
            0: return kcl_pkg::CODE_W'($urandom_range(0, 24));
            1: return kcl_pkg::CODE_W'($urandom_range(0, 9765624));
            2: return kcl_pkg::CODE_W'($urandom);
            default: return kcl_pkg::CODE_W'($urandom_range(9765625, 24'hFFFFFF));
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || merges_due.size() != 0) @(posedge i_clk);
    endtask

    // driver: bursts and gaps, changes at falling edge, holds a waiting request
    int burst_left, gap_left;
    int acc_mark;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
            acc_mark <= 0;
        end else if (!(req_if.valid && n_accepted == acc_mark)) begin
            acc_mark <= n_accepted;
            if (gap_left > 0 || hold_send || pending_reqs.size() == 0) begin
                req_if.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                req_if.valid <= 1'b1;
                {req_if.action, req_if.table_row, req_if.table_col,
                 req_if.table_value, req_if.kmer_code} <= pending_reqs[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern
    int stall_phase;
    int long_count;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_phase <= 0;
            long_count <= 0;
        end else if (long_stall && long_count < 3000) begin
            res_if.ready <= 1'b0;
            long_count <= long_count + 1;
        end else begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[8]) res_if.ready <= 1'b1;
            else res_if.ready <= ($urandom_range(0, 3) != 0) && (stall_phase % 11 != 3);
        end
    end

    // monitor, sampled at rising edge
    t_merge got, want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (req_if.valid && req_if.ready) begin
                predict_request(pending_reqs.pop_front());
                n_accepted <= n_accepted + 1;
            end
            if (res_if.valid && res_if.ready) begin
                n_merges_seen <= n_merges_seen + 1;
                got = {res_if.survivor_index, res_if.absorbed_index,
                       res_if.merge_distance, res_if.last_merge};
                if (merges_due.size() == 0) begin
                    $display("%0t unexpected merge result: expected none, actual %h",
                             $time, got);
                    n_errors <= n_errors + 1;
                end else begin
                    want = merges_due.pop_front();
                    if (got != want) begin
                        $display("%0t mismatch: expected surv %0d abs %0d dist %h last %0b",
                                 $time, want.survivor, want.absorbed, want.mdist, want.last);
                        $display("%0t           actual   surv %0d abs %0d dist %h last %0b",
                                 $time, got.survivor, got.absorbed, got.mdist, got.last);
                        n_errors <= n_errors + 1;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && idle_cycles >= WD_LIMIT) begin
            $display("FAIL kmer_complete_linkage_cluster");
            $finish;
        end
    end

    task automatic fill_table_random();
        for (int r = 0; r < kcl_pkg::SYMS; r++)
            for (int c = 0; c < kcl_pkg::SYMS; c++)
                queue_req(mk_table(r, c, ($urandom_range(0, 3) == 0) ?
                    $urandom_range(0, 65535) : $urandom_range(0, 1023)));
    endtask

    initial begin
        int n, k;
        long_stall = 0;
        hold_send = 0;
        for (int i = 0; i < NITEMS; i++) alive[i] = 1'b0;
        for (int i = 0; i < kcl_pkg::SYMS*kcl_pkg::SYMS; i++) sym_dist[i] = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: full table, extremes, ignored requests
        for (int r = 0; r < kcl_pkg::SYMS; r++)
            for (int c = 0; c < kcl_pkg::SYMS; c++)
                queue_req(mk_table(r, c, (r == c) ? 0 : 16'hFFFF));
        queue_req(mk_table(7, 2, 16'h1234));
        queue_req(mk_table(1, 5, 16'h4321));
        queue_req(mk_run());
        queue_req(mk_load(24'd0));
        queue_req(mk_run());
        queue_req(mk_load(24'd0));
        queue_req(mk_load(24'd9765624));
        queue_req(mk_load(24'hFFFFFF));
        queue_req(mk_load(24'd0));
        begin
            t_req q;
            q = mk_run();
            q.action = kcl_pkg::ACT_SPARE;
            queue_req(q);
        end
        queue_req(mk_run());
        wait_drained();

        // fill to capacity plus ignored loads, with a long receiver hold-off
        fill_table_random();
        for (int i = 0; i < NITEMS + 2; i++) queue_req(mk_load(rand_code()));
        queue_req(mk_run());
        queue_req(mk_load(rand_code()));
        queue_req(mk_load(rand_code()));
        queue_req(mk_load(rand_code()));
        queue_req(mk_run());
        while (merges_due.size() == 0) @(posedge i_clk);
        long_stall = 1;
        wait_drained();
        long_stall = 0;

        // sender pause until everything is back
        hold_send = 1;
        repeat (50) @(posedge i_clk);
        hold_send = 0;

        // random: mostly small well-formed load+run groups, some noise
        while (n_accepted < 160) begin
            k = $urandom_range(0, 9);
            if (k == 0) fill_table_random();
            else if (k == 1) queue_req(mk_table($urandom_range(0, 7),
                                 $urandom_range(0, 7), $urandom));
            else if (k == 2) begin
                t_req q;
                q = mk_run();
                q.action = kcl_pkg::ACT_W'($urandom_range(0, 3));
                queue_req(q);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 3) == 0 && i > 0)
                        queue_req(mk_load(codes[0]));
                    else queue_req(mk_load(rand_code()));
                end
                queue_req(mk_run());
            end
            wait_drained();
        end
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests, %0d runs, %0d merge results checked",
                 n_accepted, n_runs, n_merges_seen);
        if (n_errors == 0 && merges_due.size() == 0) begin
            $display("PASS kmer_complete_linkage_cluster");
        end else begin
            $display("FAIL kmer_complete_linkage_cluster");
        end
        $finish;
    end
endmodule
